@@ sv/bnse_pkg.sv @@
// Shared types and constants for the bounded number set engine.
package bnse_pkg;

	localparam int OPERAND_W = 32;
	localparam int ANSWER_W  = 38;
	localparam int FILL_W    = 7;

	typedef enum logic [1:0] {
		KIND_APPEND     = 2'd0,
		KIND_REMOVE     = 2'd1,
		KIND_COUNT_GT   = 2'd2,
		KIND_PARITY_SUM = 2'd3
	} kind_e_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_e_t;

	// Query token walking the row of cells.
	typedef struct packed {
		logic                        vld;
		kind_e_t                     kind;
		logic signed [OPERAND_W-1:0] operand;
		logic        [ANSWER_W-1:0]  acc;
		logic                        hit;   // match found (remove) or slot taken (append)
	} token_t;

endpackage

@@ sv/bnse_cell.sv @@
// One storage cell of the list: holds one entry and works on the passing token.
module bnse_cell #(
	parameter int CNT_W = 7
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  bnse_pkg::token_t                           tok_in,
	input  logic [CNT_W-1:0]                           left_in,
	input  logic signed [bnse_pkg::OPERAND_W-1:0]      nbr_entry,
	input  logic                                       nbr_pull,
	output bnse_pkg::token_t                           tok_out,
	output logic [CNT_W-1:0]                           left_out,
	output logic signed [bnse_pkg::OPERAND_W-1:0]      entry,
	output logic                                       pull
);
	import bnse_pkg::*;

	logic signed [OPERAND_W-1:0] ent_q;
	token_t                      tok_q;
	logic [CNT_W-1:0]            left_q;
	logic                        live;
	logic                        hit_here;
	logic                        app_here;
	logic [ANSWER_W-1:0]         addend;

	// entry is live while entries are still left ahead of the token
	assign live     = tok_in.vld && (left_in != '0);
	assign hit_here = (tok_in.kind == KIND_REMOVE) && live && !tok_in.hit &&
			(ent_q == tok_in.operand);
	assign app_here = (tok_in.kind == KIND_APPEND) && tok_in.vld &&
			(left_in == '0) && !tok_in.hit;
	// past the removed entry: left neighbor takes ours
	assign pull     = tok_in.vld && (tok_in.kind == KIND_REMOVE) && tok_in.hit;

	always_comb begin
		addend = '0;
		unique case (tok_in.kind)
			KIND_COUNT_GT: begin
				if (live && (ent_q > tok_in.operand))
					addend = ANSWER_W'(1);
			end
			KIND_PARITY_SUM: begin
				if (live && (ent_q[0] == tok_in.operand[0]))
					addend = ANSWER_W'(ent_q);
			end
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (app_here)
			ent_q <= tok_in.operand;
		else if (nbr_pull)
			ent_q <= nbr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			left_q <= '0;
		end else begin
			tok_q.vld     <= tok_in.vld;
			tok_q.kind    <= tok_in.kind;
			tok_q.operand <= tok_in.operand;
			tok_q.acc     <= tok_in.acc + addend;
			tok_q.hit     <= tok_in.hit | hit_here | app_here;
			left_q        <= (left_in != '0) ? left_in - CNT_W'(1) : '0;
		end
	end

	assign tok_out  = tok_q;
	assign left_out = left_q;
	assign entry    = ent_q;

endmodule

@@ sv/bounded_number_set_engine.sv @@
// Top level of the bounded number set engine: control, result register and the row of cells.
// Holds an ordered list of up to MAX_ENTRIES signed 32-bit values in a row of
// cells, one entry per cell. Each accepted item (kind, operand) launches a
// query token that walks the row one cell per cycle: each cell in turn
// compares or adds its entry, takes the operand on append
// (the first cell past the fill level), and on remove every cell beyond the
// first match hands its entry to its left neighbor, closing the gap. The
// result is registered after the token has passed the head register and
// every cell of the row; the next item is accepted once the token
// has left the row and the result register is free, so an item is not
// taken before the last one is through. Items are processed one at a time.
// Status: 0 ok, 1 full on append, 2 not found on remove. answer carries the
// count (count-greater) or the low 38 bits of the sum (parity-sum), else 0;
// fill_level is the entry count after the operation. Entry contents need no
// clearing after reset; the count and the token and control state are reset.
module bounded_number_set_engine #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     item_valid,
	output logic                                     item_stall,
	input  logic [1:0]                               kind,
	input  logic signed [bnse_pkg::OPERAND_W-1:0]    operand,
	output logic                                     result_valid,
	input  logic                                     result_stall,
	output logic [1:0]                               status,
	output logic signed [bnse_pkg::ANSWER_W-1:0]     answer,
	output logic [bnse_pkg::FILL_W-1:0]              fill_level
);
	import bnse_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

	// token chain: tok[i] enters cell i, tok[MAX_ENTRIES] leaves the row
	token_t                      tok   [0:MAX_ENTRIES];
	logic [CNT_W-1:0]            left  [0:MAX_ENTRIES];
	logic signed [OPERAND_W-1:0] ent   [0:MAX_ENTRIES-1];
	logic                        pull  [0:MAX_ENTRIES-1];
	logic [MAX_ENTRIES:0]        tok_vld_vec;

	token_t              head_tok_q;
	logic [CNT_W-1:0]    head_left_q;
	logic                busy_q;
	logic [CNT_W-1:0]    count_q;
	logic                result_valid_q;
	status_e_t           status_q;
	logic [ANSWER_W-1:0] answer_q;
	logic [FILL_W-1:0]   fill_q;

	logic                accept;
	token_t              done_tok;
	logic [CNT_W-1:0]    new_count;
	status_e_t           new_status;

	// a new item waits for the row to drain and the result register to empty
	assign item_stall = busy_q | (result_valid_q & result_stall);
	assign accept     = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_tok_q <= '0;
			busy_q     <= 1'b0;
		end else begin
			head_tok_q.vld <= accept;
			if (accept) begin
				head_tok_q.kind    <= kind_e_t'(kind);
				head_tok_q.operand <= operand;
				head_tok_q.acc     <= '0;
				head_tok_q.hit     <= 1'b0;
			end
			if (accept)
				busy_q <= 1'b1;
			else if (tok[MAX_ENTRIES].vld)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			head_left_q <= count_q;
	end

	assign tok[0]  = head_tok_q;
	assign left[0] = head_left_q;

	// row of cells
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic signed [OPERAND_W-1:0] nbr_entry;
		logic                        nbr_pull;
		if (i == MAX_ENTRIES - 1) begin : g_last
			assign nbr_entry = '0;
			assign nbr_pull  = 1'b0;
		end else begin : g_mid
			assign nbr_entry = ent[i+1];
			assign nbr_pull  = pull[i+1];
		end
		bnse_cell #(
			.CNT_W(CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok[i]),
			.left_in  (left[i]),
			.nbr_entry(nbr_entry),
			.nbr_pull (nbr_pull),
			.tok_out  (tok[i+1]),
			.left_out (left[i+1]),
			.entry    (ent[i]),
			.pull     (pull[i])
		);
	end

	// wrap-up when the token leaves the row
	assign done_tok = tok[MAX_ENTRIES];

	always_comb begin
		new_count  = count_q;
		new_status = STATUS_OK;
		unique case (done_tok.kind)
			KIND_APPEND: begin
				if (count_q == CNT_MAX)
					new_status = STATUS_FULL;
				else
					new_count = count_q + CNT_W'(1);
			end
			KIND_REMOVE: begin
				if (done_tok.hit)
					new_count = count_q - CNT_W'(1);
				else
					new_status = STATUS_NOT_FOUND;
			end
			default: new_count = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (done_tok.vld) begin
				count_q        <= new_count;
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_tok.vld) begin
			status_q <= new_status;
			answer_q <= done_tok.acc;
			fill_q   <= FILL_W'(new_count);
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign answer       = answer_q;
	assign fill_level   = fill_q;

	always_comb begin
		for (int k = 0; k <= MAX_ENTRIES; k++)
			tok_vld_vec[k] = tok[k].vld;
	end

	// at most one token in the row
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok_vld_vec))
		else $error("more than one token in the row");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_MAX)
		else $error("entry count above capacity");

	// the result register is free when a token leaves the row
	assert property (@(posedge clk) disable iff (!arst_n)
		done_tok.vld |-> !result_valid_q || !result_stall)
		else $error("token finished while result register busy");

	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy_q)
		else $error("accepted item did not start the row");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done_tok.vld && !busy_q) |-> 1'b0)
		else $error("token in flight without busy");

endmodule
